// ===== sv/sppsji_pkg.sv =====
// Shared widths, constants, command/status types and arc arithmetic for the joint inclusion block.
package sppsji_pkg;

  localparam int unsigned MAX_UNITS_DEF = 64;
  localparam int unsigned PROB_W        = 17;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned ROW_W         = 6;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             emit_pair;
    logic [ROW_W-1:0] row;
    logic             emit_diag;
    logic             emit_err;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic             adv;
    logic             cap_full;
    logic [ROW_W-1:0] j;
  } status_t;

  function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] p);
    sat_prob = (p > ONE_Q16) ? ONE_Q16 : p;
  endfunction

  function automatic logic prob_ok(input logic [PROB_W-1:0] p);
    prob_ok = !p[PROB_W-1] && (p[FRAC_W-1:0] != '0);
  endfunction

  // overlap of [a1, a1+l1) and [a2, a2+l2) on the circle, shifts -1, 0, +1 turns
  function automatic logic [PROB_W-1:0] arc_overlap(input logic [FRAC_W-1:0] a1,
                                                    input logic [PROB_W-1:0] l1,
                                                    input logic [FRAC_W-1:0] a2,
                                                    input logic [PROB_W-1:0] l2);
    logic signed [19:0] a1s;
    logic signed [19:0] b;
    logic signed [19:0] lo;
    logic signed [19:0] hi;
    logic signed [19:0] e1;
    logic signed [19:0] e2;
    logic [18:0]        total;
    a1s   = $signed({4'b0000, a1});
    e1    = a1s + $signed({3'b000, l1});
    total = '0;
    for (int k = 0; k < 3; k++) begin
      b  = $signed({4'b0000, a2}) + ((k == 0) ? -20'sd65536 :
                                     (k == 2) ?  20'sd65536 : 20'sd0);
      e2 = b + $signed({3'b000, l2});
      lo = (a1s > b) ? a1s : b;
      hi = (e1 < e2) ? e1 : e2;
      if (hi > lo) begin
        total = total + 19'(hi - lo);
      end
    end
    arc_overlap = (total > 19'(ONE_Q16)) ? ONE_Q16 : total[PROB_W-1:0];
  endfunction

endpackage

// ===== sv/sppsji_if.sv =====
// Valid/ready channel interfaces for the unit input and the result output.
interface sppsji_in_if;
  logic                           valid;
  logic                           ready;
  logic [sppsji_pkg::PROB_W-1:0]  prob;
  logic                           new_design;

  modport source (output valid, prob, new_design, input ready);
  modport sink   (input valid, prob, new_design, output ready);
endinterface

interface sppsji_out_if;
  logic                           valid;
  logic                           ready;
  logic [sppsji_pkg::ROW_W-1:0]   row_unit;
  logic [sppsji_pkg::ROW_W-1:0]   col_unit;
  logic [sppsji_pkg::PROB_W-1:0]  joint_prob;
  logic                           last_of_unit;
  logic                           capacity_error;

  modport source (output valid, row_unit, col_unit, joint_prob, last_of_unit, capacity_error,
                  input ready);
  modport sink   (input valid, row_unit, col_unit, joint_prob, last_of_unit, capacity_error,
                  output ready);
endinterface

// ===== sv/systematic_pps_joint_inclusion.sv =====
// Top level of the systematic PPS joint inclusion probability block.
//
//  channel   dir  word fields
//  item_i    in   prob[16:0], new_design
//  result_o  out  row_unit[5:0], col_unit[5:0], joint_prob[16:0], last_of_unit, capacity_error
//
// Unit j > 0 steps through accept, setup, a walk that reads each earlier unit from the unit
// store and emits its pair word, then the diagonal word.
// Unit 0 steps through accept, setup, diagonal word.
// A unit beyond capacity steps through accept and setup and gives one error word.
// The next unit is accepted once the diagonal word (or the error word) sits in the output register.
// Reset clears the unit count and running arc position; the store is not cleared.
// Stalls on result_o freeze the store read and the walk through earlier units.
module systematic_pps_joint_inclusion #(
  parameter int unsigned MAX_UNITS = sppsji_pkg::MAX_UNITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sppsji_in_if.sink     item_i,
  sppsji_out_if.source  result_o
);

  sppsji_pkg::cmd_t    cmd;
  sppsji_pkg::status_t sts;

  sppsji_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sppsji_dp #(
    .MAX_UNITS (MAX_UNITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .prob_i           (item_i.prob),
    .new_design_i     (item_i.new_design),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .row_unit_o       (result_o.row_unit),
    .col_unit_o       (result_o.col_unit),
    .joint_prob_o     (result_o.joint_prob),
    .last_of_unit_o   (result_o.last_of_unit),
    .capacity_error_o (result_o.capacity_error)
  );

endmodule

// ===== sv/sppsji_ctrl.sv =====
// Sequencer: accepts a unit, walks earlier units, emits the diagonal or error word.
module sppsji_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sppsji_pkg::status_t sts_i,
  output sppsji_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_PAIRS,
    S_DIAG
  } state_e;

  state_e                       state_q, state_d;
  logic [sppsji_pkg::ROW_W-1:0] idx_q, idx_d;
  logic [sppsji_pkg::ROW_W-1:0] rd_row_q, rd_row_d;
  logic                         rd_valid_q, rd_valid_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_row_d   = rd_row_q;
    rd_valid_d = rd_valid_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (sts_i.cap_full) begin
          if (sts_i.adv) begin
            cmd_o.emit_err = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (sts_i.j == '0) begin
          state_d = S_DIAG;
        end else begin
          idx_d      = '0;
          rd_valid_d = 1'b0;
          state_d    = S_PAIRS;
        end
      end
      S_PAIRS: begin
        if (sts_i.adv) begin
          cmd_o.emit_pair = rd_valid_q;
          cmd_o.row       = rd_row_q;
          if (idx_q != sts_i.j) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = idx_q;
            rd_row_d      = idx_q;
            rd_valid_d    = 1'b1;
            idx_d         = idx_q + 1'b1;
          end else begin
            rd_valid_d = 1'b0;
            state_d    = S_DIAG;
          end
        end
      end
      S_DIAG: begin
        if (sts_i.adv) begin
          cmd_o.emit_diag = 1'b1;
          cmd_o.commit    = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      rd_row_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_row_q   <= rd_row_d;
      rd_valid_q <= rd_valid_d;
    end
  end

endmodule

// ===== sv/sppsji_dp.sv =====
// Datapath: unit store, running arc position, joint probability arithmetic, output register.
module sppsji_dp #(
  parameter int unsigned MAX_UNITS = sppsji_pkg::MAX_UNITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sppsji_pkg::cmd_t                cmd_i,
  output sppsji_pkg::status_t             sts_o,
  input  logic [sppsji_pkg::PROB_W-1:0]   prob_i,
  input  logic                            new_design_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [sppsji_pkg::ROW_W-1:0]    row_unit_o,
  output logic [sppsji_pkg::ROW_W-1:0]    col_unit_o,
  output logic [sppsji_pkg::PROB_W-1:0]   joint_prob_o,
  output logic                            last_of_unit_o,
  output logic                            capacity_error_o
);

  localparam int unsigned IDX_W   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_UNITS + 1);
  localparam int unsigned ENTRY_W = sppsji_pkg::FRAC_W + sppsji_pkg::PROB_W;

  logic [ENTRY_W-1:0] mem [MAX_UNITS];
  logic [ENTRY_W-1:0] rdata_q;

  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [sppsji_pkg::FRAC_W-1:0]   run_q, run_d;
  logic [sppsji_pkg::PROB_W-1:0]   p_q;
  logic [CNT_W-1:0]                j_q;
  logic [sppsji_pkg::FRAC_W-1:0]   s_q;
  logic                            vj_q;

  logic                            out_valid_q, out_valid_d;
  logic [sppsji_pkg::ROW_W-1:0]    row_q;
  logic [sppsji_pkg::ROW_W-1:0]    col_q;
  logic [sppsji_pkg::PROB_W-1:0]   joint_q;
  logic                            last_q;
  logic                            err_q;

  logic [sppsji_pkg::PROB_W-1:0]   p_sat;
  logic [sppsji_pkg::PROB_W-1:0]   pi;
  logic [sppsji_pkg::FRAC_W-1:0]   ai;
  logic [32:0]                     prod;
  logic [sppsji_pkg::PROB_W-1:0]   pair_joint;

  assign p_sat = sppsji_pkg::sat_prob(prob_i);
  assign pi    = rdata_q[sppsji_pkg::PROB_W-1:0];
  assign ai    = rdata_q[ENTRY_W-1:sppsji_pkg::PROB_W];
  assign prod  = 33'(p_q) * 33'(pi);

  always_comb begin
    if (vj_q && sppsji_pkg::prob_ok(pi)) begin
      pair_joint = sppsji_pkg::arc_overlap(ai, pi, s_q, p_q);
    end else begin
      pair_joint = prod[32:16];
    end
  end

  assign sts_o.adv      = !out_valid_q || out_ready_i;
  assign sts_o.cap_full = (j_q >= CNT_W'(MAX_UNITS));
  assign sts_o.j        = sppsji_pkg::ROW_W'(j_q);

  always_comb begin
    cnt_d = cnt_q;
    run_d = run_q;
    if (cmd_i.load && new_design_i) begin
      cnt_d = '0;
      run_d = '0;
    end else if (cmd_i.commit) begin
      cnt_d = j_q + 1'b1;
      run_d = vj_q ? (s_q + p_q[sppsji_pkg::FRAC_W-1:0]) : s_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_pair || cmd_i.emit_diag || cmd_i.emit_err) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q  <= p_sat;
      vj_q <= sppsji_pkg::prob_ok(p_sat);
      j_q  <= new_design_i ? '0 : cnt_q;
      s_q  <= new_design_i ? '0 : run_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[j_q[IDX_W-1:0]] <= {s_q, p_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pair) begin
      row_q   <= cmd_i.row;
      col_q   <= sppsji_pkg::ROW_W'(j_q);
      joint_q <= pair_joint;
      last_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (cmd_i.emit_diag) begin
      row_q   <= sppsji_pkg::ROW_W'(j_q);
      col_q   <= sppsji_pkg::ROW_W'(j_q);
      joint_q <= p_q;
      last_q  <= 1'b1;
      err_q   <= 1'b0;
    end else if (cmd_i.emit_err) begin
      row_q   <= '0;
      col_q   <= '0;
      joint_q <= '0;
      last_q  <= 1'b0;
      err_q   <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_unit_o       = row_q;
  assign col_unit_o       = col_q;
  assign joint_prob_o     = joint_q;
  assign last_of_unit_o   = last_q;
  assign capacity_error_o = err_q;

endmodule
